[rtl/isk_pkg.sv]
package isk_pkg;

  localparam int ISK_DEPTH = 64;
  localparam int ISK_WIDTH = 32;

  // Field widths of the stream words
  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int REND_W  = 6;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int ERR_W   = 2;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 48;

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_DELR   = 3'd4,
    OP_READ   = 3'd5,
    OP_TOP    = 3'd6,
    OP_CLEAR  = 3'd7
  } isk_op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK     = 2'd0,
    ERR_FULL   = 2'd1,
    ERR_EMPTY  = 2'd2,
    ERR_BOUNDS = 2'd3
  } isk_err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_SHRINK,
    S_FETCH,
    S_CAPTURE,
    S_FINISH
  } isk_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // latch the input word
    logic setup;    // latch error code, set up the shift loop
    logic rd_src;   // read the entry at the shift source
    logic wr_move;  // write the moved entry, step the loop
    logic put;      // write the new value, count up
    logic shrink;   // count down by the deleted span
    logic fetch;    // read the addressed entry (pop counts down)
    logic capture;  // take the read data
    logic clear;    // count to zero
    logic finish;   // load the result register
  } isk_ctl_t;

  // Datapath to controller
  typedef struct packed {
    isk_op_t op;
    logic    bad;
    logic    moves_zero;
    logic    out_busy;
  } isk_sts_t;

endpackage

[rtl/isk_ram.sv]
module isk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/isk_datapath.sv]
module isk_datapath #(
  parameter int DEPTH = isk_pkg::ISK_DEPTH,
  parameter int WIDTH = isk_pkg::ISK_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  isk_pkg::isk_ctl_t       ctl,
  output isk_pkg::isk_sts_t       sts,
  input  logic [isk_pkg::IN_W-1:0]  in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [isk_pkg::OUT_W-1:0] out_word
);

  import isk_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;

  isk_op_t           op_q;
  logic [POS_W-1:0]  pos_q;
  logic [REND_W-1:0] rend_q;
  logic [WIDTH-1:0]  val_q;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     src;
  logic [AW-1:0]     dst;
  logic [CW-1:0]     moves;
  logic              down;
  isk_err_t          err_q;
  logic [DATA_W-1:0] data_q;

  logic [DATA_W-1:0]  out_data;
  logic [COUNT_W-1:0] out_count;
  logic               out_empty;
  isk_err_t           out_err;

  logic [IW-1:0]  pos_x;
  logic [IW-1:0]  hi_x;
  logic [IW-1:0]  cnt_x;
  logic           full;
  logic           empty;
  isk_err_t       err_c;
  logic [AW-1:0]  put_addr;
  logic [AW-1:0]  fetch_addr;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [WIDTH-1:0] ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [WIDTH-1:0] ram_rdata;

  assign pos_x = IW'(pos_q);
  // single delete is a range of one
  assign hi_x  = (op_q == OP_DELR) ? IW'(rend_q) : pos_x;
  assign cnt_x = IW'(cnt);
  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);

  always_comb begin
    err_c = ERR_OK;
    unique case (op_q)
      OP_PUSH: begin
        if (full) err_c = ERR_FULL;
      end
      OP_POP, OP_TOP: begin
        if (empty) err_c = ERR_EMPTY;
      end
      OP_INSERT: begin
        if (full) err_c = ERR_FULL;
        else if (pos_x > cnt_x) err_c = ERR_BOUNDS;
      end
      OP_DELETE: begin
        if (empty) err_c = ERR_EMPTY;
        else if (pos_x >= cnt_x) err_c = ERR_BOUNDS;
      end
      OP_DELR: begin
        if (empty) err_c = ERR_EMPTY;
        else if (pos_x > hi_x || hi_x >= cnt_x) err_c = ERR_BOUNDS;
      end
      OP_READ: begin
        if (pos_x >= cnt_x) err_c = ERR_BOUNDS;
      end
      OP_CLEAR: err_c = ERR_OK;
      default:  err_c = ERR_OK;
    endcase
  end

  assign put_addr   = (op_q == OP_INSERT) ? AW'(pos_x) : AW'(cnt);
  assign fetch_addr = (op_q == OP_READ) ? AW'(pos_x) : AW'(cnt - CW'(1));

  assign ram_we    = ctl.wr_move | ctl.put;
  assign ram_waddr = ctl.wr_move ? dst : put_addr;
  assign ram_wdata = ctl.wr_move ? ram_rdata : val_q;
  assign ram_raddr = ctl.rd_src ? src : fetch_addr;

  isk_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Input word latch and loop registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q   <= isk_op_t'(in_word[CMD_W-1:0]);
      pos_q  <= in_word[CMD_W +: POS_W];
      rend_q <= in_word[CMD_W+POS_W +: REND_W];
      val_q  <= WIDTH'(in_word[CMD_W+POS_W+REND_W +: VALUE_W]);
    end
    if (ctl.setup) begin
      err_q  <= err_c;
      data_q <= '0;
      if (op_q == OP_INSERT) begin
        // walk down from the top, each entry moves up one place
        down  <= 1'b1;
        src   <= AW'(cnt - CW'(1));
        dst   <= AW'(cnt);
        moves <= CW'(cnt_x - pos_x);
      end else begin
        // entries above the span move down to its first index
        down  <= 1'b0;
        src   <= AW'(hi_x + IW'(1));
        dst   <= AW'(pos_x);
        moves <= CW'(cnt_x - hi_x - IW'(1));
      end
    end
    if (ctl.wr_move) begin
      src   <= down ? src - AW'(1) : src + AW'(1);
      dst   <= down ? dst - AW'(1) : dst + AW'(1);
      moves <= moves - CW'(1);
    end
    if (ctl.capture) begin
      data_q <= DATA_W'(ram_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.clear) begin
      cnt <= '0;
    end else if (ctl.put) begin
      cnt <= cnt + CW'(1);
    end else if (ctl.fetch && op_q == OP_POP) begin
      cnt <= cnt - CW'(1);
    end else if (ctl.shrink) begin
      cnt <= CW'(cnt_x - (hi_x - pos_x + IW'(1)));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_data  <= data_q;
      out_count <= COUNT_W'(cnt);
      out_empty <= empty;
      out_err   <= err_q;
    end
  end

  assign out_word = {6'd0, out_err, out_empty, out_count, out_data};

  assign sts.op         = op_q;
  assign sts.bad        = (err_c != ERR_OK);
  assign sts.moves_zero = (moves == '0);
  assign sts.out_busy   = out_valid & ~out_ready;

endmodule

[rtl/isk_ctrl.sv]
module isk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  isk_pkg::isk_sts_t sts,
  output isk_pkg::isk_ctl_t ctl
);

  import isk_pkg::*;

  isk_state_t state;
  isk_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.bad) begin
          state_next = S_FINISH;
        end else begin
          unique case (sts.op)
            OP_PUSH:                     state_next = S_PUT;
            OP_INSERT, OP_DELETE, OP_DELR: state_next = S_MOVE_RD;
            OP_POP, OP_READ, OP_TOP:     state_next = S_FETCH;
            OP_CLEAR:                    state_next = S_FINISH;
            default:                     state_next = S_FINISH;
          endcase
        end
      end
      S_MOVE_RD: begin
        if (!sts.moves_zero) state_next = S_MOVE_WR;
        else if (sts.op == OP_INSERT) state_next = S_PUT;
        else state_next = S_SHRINK;
      end
      S_MOVE_WR: state_next = S_MOVE_RD;
      S_PUT:     state_next = S_FINISH;
      S_SHRINK:  state_next = S_FINISH;
      S_FETCH:   state_next = S_CAPTURE;
      S_CAPTURE: state_next = S_FINISH;
      S_FINISH: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_CHECK: begin
        ctl.setup = 1'b1;
        ctl.clear = (sts.op == OP_CLEAR);
      end
      S_MOVE_RD: ctl.rd_src  = ~sts.moves_zero;
      S_MOVE_WR: ctl.wr_move = 1'b1;
      S_PUT:     ctl.put     = 1'b1;
      S_SHRINK:  ctl.shrink  = 1'b1;
      S_FETCH:   ctl.fetch   = 1'b1;
      S_CAPTURE: ctl.capture = 1'b1;
      S_FINISH:  ctl.finish  = ~sts.out_busy;
      default: ;
    endcase
  end

endmodule

[rtl/indexed_stack_engine.sv]
// Ordered store of up to DEPTH entries of WIDTH bits with a count: push,
// pop, insert or delete at an index, delete an index range, read by index,
// read top, clear. One result word per command word. Entries sit in a
// single-port-write, registered-read RAM, so inserts and deletes move the
// entries one at a time to open or close the gap. Every command is checked
// first; a push writes its value, pop, read and top fetch and capture the
// entry, clear and refused commands go straight to the result register.
// Insert and the deletes read and write each moved entry (insert at p
// moves count-p entries, a delete ending at e moves count-1-e), then write
// or shrink. The next word is taken in the cycle after the result is
// loaded, even while the result still waits on the output side. A waiting
// result holds the following command in its last cycle. Full, empty and
// out-of-range commands are refused and leave the store as it was.
module indexed_stack_engine #(
  parameter int DEPTH = isk_pkg::ISK_DEPTH,
  parameter int WIDTH = isk_pkg::ISK_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // cmd[2:0], position[9:3], range_end[15:10], value[47:16]
  input  logic [isk_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // data[31:0], count[38:32], is_empty[39], error[41:40], zero[47:42]
  output logic [isk_pkg::OUT_W-1:0] m_tdata
);

  import isk_pkg::*;

  isk_ctl_t ctl;
  isk_sts_t sts;

  isk_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .ctl     (ctl)
  );

  isk_datapath #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .in_word  (s_tdata),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_word (m_tdata)
  );

  // every accepted word is checked in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ctl.setup)
    else $error("accepted word not checked");

  // refused commands return zero data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[41:40] != ERR_OK |-> m_tdata[31:0] == '0)
    else $error("refused command with data");

  assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> m_tvalid)
    else $error("result not presented");

  // the store is never written while idle
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(ctl.put || ctl.wr_move))
    else $error("store written while idle");

endmodule
